@@ hw/rtl/grm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Gated ring multiplier package
// Shared types, action codes, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package grm_pkg;

  localparam int unsigned SampleBits = 24;
  localparam int unsigned ActionW = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 18;

  localparam logic [ActionW-1:0] ActSample   = 2'd0;
  localparam logic [ActionW-1:0] ActPrepare  = 2'd1;
  localparam logic [ActionW-1:0] ActNoteOn   = 2'd2;
  // The remaining code is accepted but changes nothing.
  localparam logic [ActionW-1:0] ActReserved = 2'd3;

  localparam logic [CfgIdxW-1:0] RegDryWet     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFreq       = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWidthOne   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFactor     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWidthTwo   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSampleRate = 3'd5;

  localparam logic signed [39:0] OneQ30  = 40'sd1073741824;
  localparam logic signed [39:0] HalfQ30 = 40'sd536870912;

  // Payload of one input item.
  typedef struct packed {
    logic [1:0]                  action;
    logic signed [SampleBits-1:0] sample_left;
    logic signed [SampleBits-1:0] sample_right;
    logic                        mono_in;
    logic [12:0]                 frame_count;
    logic [23:0]                 note_freq;
    logic signed [15:0]          freq_mod;
    logic signed [15:0]          mod_width_one;
    logic signed [15:0]          gain_mod;
    logic signed [15:0]          mod_width_two;
    logic                        glide;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] out_left;
    logic signed [SampleBits-1:0] out_right;
    logic                        gate_open;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_item_t;

  // Knob in Q0.16 to Q1.30, top code meaning exactly one.
  function automatic logic signed [39:0] knob(input logic [15:0] k);
    knob = (k == 16'hFFFF) ? OneQ30 : $signed({10'd0, k, 14'd0});
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/grm_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Valid/ready channel
// Generic handshake channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface grm_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/grm_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Radix-2 divider
// Unsigned restoring division, one quotient bit per cycle, 64 / 64 bits.
// ----------------------------------------------------------------------------
module grm_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] num_i,
  input  wire logic [63:0] den_i,
  output logic             done_o,
  output logic [63:0]      quo_o
);
  logic [63:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [64:0] trial;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; cnt_d = cnt_q; busy_d = busy_q;
    trial = {rem_q, quo_q[63]} - {1'b0, den_q};
    if (start_i) begin
      rem_d = '0; quo_d = num_i; den_d = den_i; cnt_d = 7'd64; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = busy_q && (cnt_q == 7'd1);
  assign quo_o  = quo_d;
endmodule
`default_nettype wire

@@ hw/rtl/gated_ring_multiplier_interp_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Gated ring multiplier, top level
// Sequenced ring modulator with per-sample glide of its parameters.
// ----------------------------------------------------------------------------
// Channels: in_if takes items (sample, prepare, note on), out_if gives one
// result for each sample item, cfg_if writes the six knob registers. The user
// must write them only while the block is idle; the block does not enforce it.
// Transfers complete when valid and ready are both high. A sample item uses
// one shared 32x32 multiplier over four steps, then an output step registers
// its result; the next item can transfer only after the result transfers.
// A prepare item runs 64-bit divisions on one shared radix-2 divider: the
// rate, the window start when the widths sum above one and five steps when
// the frame count is not zero.
// The block takes one item at a time; in_if.ready is low while it works and
// while a result waits in the output register, so a stalled receiver holds
// the block. Reset clears all glide state and phase and loads the knob
// defaults.
// ----------------------------------------------------------------------------
module gated_ring_multiplier_interp_top (
  input wire logic clk_i,
  input wire logic rst_ni,
  grm_if.sink      in_if,
  grm_if.source    out_if,
  grm_if.sink      cfg_if
);
  import grm_pkg::*;

  localparam logic [4:0] SIdle = 5'd0, SMul = 5'd1, SOut = 5'd2, SPrep = 5'd3,
                         SDiv = 5'd4, SWait = 5'd5, SAdv = 5'd6;

  logic [15:0] dry_wet_q, freq_q, w1_q, fac_q, w2_q;
  logic [17:0] sr_q;
  logic [31:0] phase_q;
  logic [31:0] now_q [5];   // mix, rate, start, gain, stop
  logic [31:0] step_q [5];
  logic [4:0]  st_q;
  logic [3:0]  mstep_q;
  logic [2:0]  dstep_q;
  in_item_t    it_q;
  out_item_t   res_q;
  logic        res_v_q, open_q;
  logic signed [39:0] tgt_q [5];
  logic signed [39:0] prod_q, ta_q;
  logic [32:0] sq_q;

  // Shared multiplier
  logic signed [31:0] ma;
  logic signed [31:0] mb;
  logic signed [63:0] mp;
  assign mp = ma * mb;

  function automatic logic signed [39:0] rsh30(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + 64'sd536870912;
    rsh30 = 40'($signed(t[63:30]));
  endfunction

  function automatic logic signed [SampleBits-1:0] sat(input logic signed [39:0] v);
    logic signed [39:0] lim;
    lim = 40'sd1 <<< (SampleBits - 1);
    if (v >= lim) sat = SampleBits'(lim - 40'sd1);
    else if (v < -lim) sat = SampleBits'(-lim);
    else sat = SampleBits'(v);
  endfunction

  logic signed [39:0] mix_c;
  always_comb begin
    mix_c = 40'($signed(now_q[0]));
    if (mix_c < 0) mix_c = '0;
    else if (mix_c > OneQ30) mix_c = OneQ30;
  end

  logic signed [39:0] xl, xr;
  assign xl = 40'(it_q.sample_left);
  assign xr = 40'(it_q.sample_right);

  // Multiply schedule: 0 wetL, 1 mixL, 2 wetR, 3 mixR.
  always_comb begin
    ma = '0; mb = '0;
    case (mstep_q)
      4'd0: begin ma = 32'(xl); mb = $signed(now_q[3]); end
      4'd1: begin ma = 32'(ta_q - xl); mb = 32'(mix_c); end
      4'd2: begin ma = 32'(xr); mb = $signed(now_q[3]); end
      4'd3: begin ma = 32'(ta_q - xr); mb = 32'(mix_c); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // Divider operands
  logic        dv_start, dv_done;
  logic [63:0] dv_num, dv_den, dv_quo;
  logic signed [39:0] w1c, w2c, sumw, tq, sq;
  logic signed [63:0] diff;
  logic [63:0] adiff, dmag;
  logic        dneg;
  logic [63:0] srx;
  logic [56:0] rate_num;

  always_comb begin
    w1c = knob(w1_q) + (40'(it_q.mod_width_one) <<< 15);
    if (w1c < 0) w1c = '0; else if (w1c > 4 * OneQ30) w1c = 4 * OneQ30;
    w2c = knob(w2_q) + (40'(it_q.mod_width_two) <<< 15);
    if (w2c < 0) w2c = '0; else if (w2c > 4 * OneQ30) w2c = 4 * OneQ30;
    sumw = w1c + w2c;
    tq = knob(freq_q) + (40'(it_q.freq_mod) <<< 15);
    if (tq < 0) tq = '0; else if (tq > OneQ30) tq = OneQ30;
    if (tq < HalfQ30) sq = (OneQ30 >>> 2) + ((40'sd3 * tq) >>> 1);
    else sq = OneQ30 + 40'sd6 * (tq - HalfQ30);
    srx = {33'd0, (sr_q == '0) ? 18'd1 : sr_q, 13'd0};
  end

  // The frequency scale is registered before it meets the note frequency.
  assign rate_num = sq_q * it_q.note_freq;

  // Step divisions: indexes 0..4 of now/target; dstep 5 and 6 are the rate and the window start.
  logic [2:0] didx;
  assign didx = dstep_q;
  always_comb begin
    diff  = 64'(tgt_q[didx]) - 64'($signed(now_q[didx]));
    dneg  = diff[63];
    adiff = dneg ? 64'(-diff) : 64'(diff);
  end

  logic signed [64:0] qs;
  logic [31:0] stepv;
  always_comb begin
    qs = dneg ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo});
    if (qs > 65'sd2147483647) stepv = 32'h7FFFFFFF;
    else if (qs < -65'sd2147483648) stepv = 32'h80000000;
    else stepv = qs[31:0];
  end

  grm_div u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .done_o(dv_done), .quo_o(dv_quo)
  );

  // Divider job select: dstep 5 rate, 6 start, 0..4 steps.
  always_comb begin
    dv_num = '0; dv_den = 64'd1;
    if (dstep_q == 3'd5) begin
      dv_num = {7'd0, rate_num};
      dv_den = srx;
    end else if (dstep_q == 3'd6) begin
      dv_num = 64'(w1c) << 30;
      dv_den = 64'(sumw);
    end else begin
      dv_num = adiff;
      dv_den = {51'd0, it_q.frame_count};
    end
  end
  assign dmag = dv_quo;

  logic in_fire, out_fire;
  assign in_if.ready  = (st_q == SIdle) && !res_v_q;
  assign in_fire      = in_if.valid && in_if.ready;
  assign out_if.valid = res_v_q;
  assign out_if.data  = res_q;
  assign out_fire     = res_v_q && out_if.ready;
  assign cfg_if.ready = 1'b1;

  logic signed [39:0] wet_l_q;
  logic [63:0] phx;
  assign phx = {32'd0, phase_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dry_wet_q <= 16'd65535; freq_q <= 16'd32768; w1_q <= 16'd21823;
      fac_q <= 16'd65535; w2_q <= 16'd21823; sr_q <= 18'd48000;
      phase_q <= '0; st_q <= SIdle; res_v_q <= 1'b0;
      mstep_q <= '0; dstep_q <= '0; dv_start <= 1'b0; open_q <= 1'b0;
      ta_q <= '0; wet_l_q <= '0; prod_q <= '0; res_q <= '0; sq_q <= '0;
      for (int i = 0; i < 5; i++) begin
        now_q[i] <= '0; step_q[i] <= '0; tgt_q[i] <= '0;
      end
    end else begin
      dv_start <= 1'b0;
      if (out_fire) res_v_q <= 1'b0;
      if (cfg_if.valid) begin
        case (cfg_if.data.index)
          RegDryWet:     dry_wet_q <= cfg_if.data.data[15:0];
          RegFreq:       freq_q    <= cfg_if.data.data[15:0];
          RegWidthOne:   w1_q      <= cfg_if.data.data[15:0];
          RegFactor:     fac_q     <= cfg_if.data.data[15:0];
          RegWidthTwo:   w2_q      <= cfg_if.data.data[15:0];
          RegSampleRate: sr_q      <= cfg_if.data.data;
          default: ;
        endcase
      end
      case (st_q)
        SIdle: if (in_fire) begin
          case (in_if.data.action)
            ActSample: begin
              st_q <= SMul; mstep_q <= '0;
              open_q <= ($signed({1'b0, phx}) >= $signed(65'($signed(now_q[2])) <<< 2))
                     && ($signed({1'b0, phx}) < $signed(65'($signed(now_q[4])) <<< 2));
            end
            ActPrepare: st_q <= SPrep;
            ActNoteOn: if (!in_if.data.glide) phase_q <= '0;
            default: ;
          endcase
        end
        SMul: begin
          mstep_q <= mstep_q + 4'd1;
          case (mstep_q)
            4'd0: ta_q <= open_q ? rsh30(mp) : xl;
            4'd1: wet_l_q <= xl + rsh30(mp);
            4'd2: ta_q <= open_q ? rsh30(mp) : xr;
            4'd3: begin prod_q <= xr + rsh30(mp); st_q <= SOut; end
            default: ;
          endcase
        end
        SOut: begin
          res_q.out_left  <= sat(wet_l_q);
          res_q.out_right <= it_q.mono_in ? sat(wet_l_q) : sat(prod_q);
          res_q.gate_open <= open_q;
          res_v_q <= 1'b1;
          phase_q <= phase_q + {now_q[1][24:0], 7'd0};
          for (int i = 0; i < 5; i++) now_q[i] <= now_q[i] + step_q[i];
          st_q <= SIdle;
        end
        SPrep: begin
          tgt_q[0] <= knob(dry_wet_q);
          tgt_q[3] <= 40'sd2 * knob(fac_q) - OneQ30 + (40'(it_q.gain_mod) <<< 15);
          if (sumw > OneQ30) tgt_q[4] <= OneQ30;
          else begin tgt_q[4] <= sumw; tgt_q[2] <= w1c; end
          sq_q <= sq[32:0];
          dstep_q <= 3'd5; dv_start <= 1'b1; st_q <= SDiv;
        end
        SDiv: st_q <= SWait;
        SWait: if (dv_done) begin
          if (dstep_q == 3'd5) begin
            tgt_q[1] <= (dmag > 64'd2147483647) ? 40'sd2147483647 : 40'(dmag);
            if (sumw > OneQ30) begin
              dstep_q <= 3'd6; dv_start <= 1'b1; st_q <= SDiv;
            end else st_q <= SAdv;
          end else if (dstep_q == 3'd6) begin
            tgt_q[2] <= 40'(dmag); st_q <= SAdv;
          end else begin
            step_q[didx] <= stepv;
            if (dstep_q == 3'd4) st_q <= SIdle;
            else begin dstep_q <= dstep_q + 3'd1; dv_start <= 1'b1; st_q <= SDiv; end
          end
        end
        SAdv: begin
          if (it_q.frame_count == '0) begin
            for (int i = 0; i < 5; i++) begin
              now_q[i] <= tgt_q[i][31:0]; step_q[i] <= '0;
            end
            st_q <= SIdle;
          end else begin
            dstep_q <= 3'd0; dv_start <= 1'b1; st_q <= SDiv;
          end
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) it_q <= in_if.data;
  end

  // A result is only posted from the output step of a sample item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_v_q) |-> $past(st_q) == SOut) else $error("result without sample");
  // Input is never taken while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q |-> !in_if.ready) else $error("ready with pending result");
  // The divider is only started while a prepare item runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_start |-> st_q == SDiv) else $error("stray divider start");

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gated ring multiplier testbench
// Sends sample, prepare, note on and reserved items into the block. A predictor
// written here tracks the phase, the glide values and the knob registers, and
// works out each expected output sample. Results are compared field by field
// in order. A directed table runs first. Random phases then follow under
// several knob settings and several idle patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import grm_pkg::*;

  localparam longint One = 64'sd1073741824;
  localparam longint Half = 64'sd536870912;
  localparam int unsigned DrainCycles = 600;
  localparam int unsigned StallLimit = 20000;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  grm_if #(.T(in_item_t))  in_ch ();
  grm_if #(.T(out_item_t)) out_ch ();
  grm_if #(.T(cfg_item_t)) cfg_ch ();

  gated_ring_multiplier_interp_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #5 clk_i = ~clk_i;

  // Knob registers and glide state as the predictor sees them.
  logic [17:0] knob_reg [6];
  logic [31:0] phase_acc;
  logic [31:0] mix_cur, mix_inc, rate_cur, rate_inc, start_cur, start_inc;
  logic [31:0] gain_cur, gain_inc, stop_cur, stop_inc;

  out_item_t   expected_samples [$];
  int unsigned error_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles = 0;
  dir_row_t    dir_rows [$];

  function automatic longint s32(logic [31:0] u);
    return longint'($signed(u));
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint round_q30(longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint knob_q30(logic [17:0] k);
    return k[15:0] == 16'hFFFF ? One : longint'(k[15:0]) * 16384;
  endfunction

  function automatic logic [31:0] glide_step(longint target, logic [31:0] cur,
                                             logic [12:0] frames);
    longint d;
    d = (target - s32(cur)) / longint'({51'd0, frames});
    d = clamp(d, -64'sd2147483648, 64'sd2147483647);
    return d[31:0];
  endfunction

  function automatic logic [23:0] mix_sample(logic signed [23:0] smp, bit open);
    longint x, wet, y, mix;
    x = longint'(smp);
    mix = clamp(s32(mix_cur), 0, One);
    wet = open ? round_q30(x * s32(gain_cur)) : x;
    y = x + round_q30((wet - x) * mix);
    y = clamp(y, -64'sd8388608, 64'sd8388607);
    return y[23:0];
  endfunction

  function automatic void load_targets(in_item_t it);
    longint t, s, w1, w2, sum, start, stop, factor, mix, rate;
    longint unsigned prod, sr, q;
    sr = knob_reg[RegSampleRate] == 0 ? 1 : longint'(knob_reg[RegSampleRate]);
    mix = knob_q30(knob_reg[RegDryWet]);
    t = clamp(knob_q30(knob_reg[RegFreq]) + longint'(it.freq_mod) * 32768, 0, One);
    s = t < Half ? One / 4 + (3 * t) / 2 : One + 6 * (t - Half);
    prod = longint'(s) * longint'({40'd0, it.note_freq});
    q = prod / (sr << 13);
    rate = q > 64'd2147483647 ? 64'sd2147483647 : longint'(q);
    w1 = clamp(knob_q30(knob_reg[RegWidthOne]) + longint'(it.mod_width_one) * 32768,
               0, 4 * One);
    w2 = clamp(knob_q30(knob_reg[RegWidthTwo]) + longint'(it.mod_width_two) * 32768,
               0, 4 * One);
    sum = w1 + w2;
    if (sum > One) begin
      start = (w1 * One) / sum;
      stop = One;
    end else begin
      start = w1;
      stop = sum;
    end
    factor = 2 * knob_q30(knob_reg[RegFactor]) - One + longint'(it.gain_mod) * 32768;
    if (it.frame_count == 0) begin
      mix_cur = mix[31:0];      mix_inc = '0;
      rate_cur = rate[31:0];    rate_inc = '0;
      start_cur = start[31:0];  start_inc = '0;
      gain_cur = factor[31:0];  gain_inc = '0;
      stop_cur = stop[31:0];    stop_inc = '0;
    end else begin
      mix_inc = glide_step(mix, mix_cur, it.frame_count);
      rate_inc = glide_step(rate, rate_cur, it.frame_count);
      start_inc = glide_step(start, start_cur, it.frame_count);
      gain_inc = glide_step(factor, gain_cur, it.frame_count);
      stop_inc = glide_step(stop, stop_cur, it.frame_count);
    end
  endfunction

  // Advances the predicted state by one accepted item; returns 1 when the
  // item yields an output sample.
  function automatic bit apply_item(in_item_t it, output out_item_t res);
    longint ph;
    bit open;
    res = '0;
    case (it.action)
      ActPrepare: begin
        load_targets(it);
        return 1'b0;
      end
      ActNoteOn: begin
        if (!it.glide) phase_acc = '0;
        return 1'b0;
      end
      ActSample: begin
        ph = longint'({32'd0, phase_acc});
        open = ph >= s32(start_cur) * 4 && ph < s32(stop_cur) * 4;
        res.out_left = mix_sample(it.sample_left, open);
        res.out_right = it.mono_in ? res.out_left : mix_sample(it.sample_right, open);
        res.gate_open = open;
        mix_cur = mix_cur + mix_inc;
        phase_acc = phase_acc + {rate_cur[24:0], 7'd0};
        rate_cur = rate_cur + rate_inc;
        start_cur = start_cur + start_inc;
        gain_cur = gain_cur + gain_inc;
        stop_cur = stop_cur + stop_inc;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic in_item_t mk(logic [1:0] act, int l, int r, bit mono,
                                  int frames, int nf, int mf, int m1, int mfac,
                                  int m2, bit gl);
    in_item_t it;
    it.action = act;
    it.sample_left = l[23:0];
    it.sample_right = r[23:0];
    it.mono_in = mono;
    it.frame_count = frames[12:0];
    it.note_freq = nf[23:0];
    it.freq_mod = mf[15:0];
    it.mod_width_one = m1[15:0];
    it.gain_mod = mfac[15:0];
    it.mod_width_two = m2[15:0];
    it.glide = gl;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    logic [159:0] raw;
    int unsigned pick;
    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    it = raw[$bits(in_item_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 72) it.action = ActSample;
    else if (pick < 88) it.action = ActPrepare;
    else if (pick < 97) it.action = ActNoteOn;
    else it.action = ActReserved;
    pick = $urandom_range(99);
    if (pick < 80) it.frame_count = 13'($urandom_range(0, 32));
    else if (pick < 95) it.frame_count = 13'($urandom_range(0, 4096));
    if ($urandom_range(3) == 0) it.note_freq = 24'($urandom_range(0, 2000 * 256));
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    out_item_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    if (apply_item(it, res)) expected_samples.push_back(res);
  endtask

  task automatic write_knobs(logic [17:0] vals [6]);
    for (int i = 0; i < 6; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.data <= '{index: i[CfgIdxW-1:0], data: vals[i]};
      do @(posedge clk_i); while (!cfg_ch.ready);
      knob_reg[i] = vals[i];
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Empties the output queue, then lets a prepare still in flight finish.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Output side: compare each transfer, then pick the next ready level.
  always @(posedge clk_i) begin
    out_item_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected output sample %h", $time, out_ch.data);
        error_count++;
      end else begin
        want = expected_samples.pop_front();
        if (out_ch.data.out_left !== want.out_left) begin
          $display("%0t: out_left expected %h actual %h", $time, want.out_left,
                   out_ch.data.out_left);
          error_count++;
        end
        if (out_ch.data.out_right !== want.out_right) begin
          $display("%0t: out_right expected %h actual %h", $time, want.out_right,
                   out_ch.data.out_right);
          error_count++;
        end
        if (out_ch.data.gate_open !== want.gate_open) begin
          $display("%0t: gate_open expected %b actual %b", $time, want.gate_open,
                   out_ch.data.gate_open);
          error_count++;
        end
      end
    end
    out_ch.ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("gated_ring_multiplier_interp_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [17:0] vals [6];
    in_item_t    it;
    out_item_t   res;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    knob_reg = '{18'd65535, 18'd32768, 18'd21823, 18'd65535, 18'd21823, 18'd48000};
    phase_acc = '0;
    {mix_cur, mix_inc, rate_cur, rate_inc, start_cur, start_inc} = '0;
    {gain_cur, gain_inc, stop_cur, stop_inc} = '0;

    // After reset the mix is zero and the window is empty, so samples pass dry.
    dir_rows = '{
      '{mk(ActSample, 8388607, -8388608, 0, 0, 0, 0, 0, 0, 0, 0), 1,
        '{24'h7FFFFF, 24'h800000, 1'b0}},
      '{mk(ActSample, -8388608, 8388607, 0, 0, 0, 0, 0, 0, 0, 0), 1,
        '{24'h800000, 24'h7FFFFF, 1'b0}},
      '{mk(ActSample, 24'h123456, -1, 1, 0, 0, 0, 0, 0, 0, 0), 1,
        '{24'h123456, 24'h123456, 1'b0}},
      '{mk(ActReserved, 5, 5, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(ActNoteOn, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(ActPrepare, 0, 0, 0, 0, 440 * 256, 0, 0, 0, 0, 0), 0, '0},
      '{mk(ActSample, 8388607, -8388608, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(ActPrepare, 0, 0, 0, 0, 16777215, 32767, 32767, 32767, 32767, 0), 0, '0},
      '{mk(ActSample, 8388607, -8388608, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(ActSample, -8388608, 8388607, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(ActSample, 4000000, -4000000, 1, 0, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(ActPrepare, 0, 0, 0, 0, 0, -32768, -32768, -32768, -32768, 0), 0, '0},
      '{mk(ActSample, 8388607, 1, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(ActPrepare, 0, 0, 0, 1, 16777215, 32767, -32768, 32767, 16000, 0), 0, '0},
      '{mk(ActSample, 8388607, -8388608, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(ActSample, 8388607, -8388608, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(ActSample, -123456, 654321, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(ActPrepare, 0, 0, 0, 8191, 1000 * 256, -20000, 9000, -32768, 5000, 1), 0, '0},
      '{mk(ActSample, 7000000, -7000000, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(ActNoteOn, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 0, '0},
      '{mk(ActSample, 1, -1, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(ActNoteOn, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(ActPrepare, 0, 0, 0, 3, 24'h0FFFFF, 12000, 0, -32768, 0, 0), 0, '0},
      '{mk(ActSample, 8388607, -8388608, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(ActSample, -8388608, 8388607, 1, 0, 0, 0, 0, 0, 0, 0), 0, '0}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 18;
    recv_idle_pct = 76;
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].item);
      if (dir_rows[i].typed) begin
        res = expected_samples.pop_back();
        expected_samples.push_back(dir_rows[i].result);
      end
    end

    for (int p = 0; p < 6; p++) begin
      drain();
      for (int k = 0; k < 6; k++) begin
        if (p == 0) vals[k] = '0;
        else if (p == 1) vals[k] = k == RegSampleRate ? 18'h3FFFF : 18'd65535;
        else if (k == RegSampleRate) vals[k] = 18'($urandom_range(8000, 192000));
        else vals[k] = 18'($urandom_range(0, 262143));
      end
      write_knobs(vals);
      send_idle_pct = p < 2 ? 18 : (p < 4 ? 76 : 0);
      recv_idle_pct = p < 2 ? 76 : (p < 4 ? 18 : 0);
      for (int n = 0; n < 255; n++) begin
        it = random_item();
        send_item(it);
      end
    end

    drain();
    if (error_count == 0) begin
      $display("gated_ring_multiplier_interp_top verification clean");
    end else begin
      $display("gated_ring_multiplier_interp_top verification failed");
    end
    $finish;
  end

endmodule
